// File: hw/rtl/edma_pkg.sv
package edma_pkg;

    // Field widths
    localparam int PW_W   = 16;   // pulse width in microseconds
    localparam int CM_W   = 10;   // distance and limit fields
    localparam int DIST_W = 11;   // raw distance, up to 1126 cm
    localparam int SUM_W  = 14;   // window sum, up to 16 * 1023

    // Defaults for the top-level parameters
    localparam int WINDOW_DEF     = 10;
    localparam int FIFO_DEPTH_DEF = 4;

    // floor(floor(w/2) * 10 / 291) as a reciprocal multiply.
    // x = floor(w/2) * 10 is below 2^19, DIST_MULT = ceil(2^28 / 291),
    // and the rounding error stays below one step for every such x.
    localparam int               DIST_X_W   = 19;
    localparam int               DIST_SHIFT = 28;
    localparam int               DIST_P_W   = 39;
    localparam logic [19:0]      DIST_MULT  = 20'd922459;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CM_W-1:0] LOW_RST  = 10'd2;
    localparam logic [CM_W-1:0] HIGH_RST = 10'd400;

    typedef enum logic [0:0] {
        REG_LOW_LIMIT  = 1'b0,
        REG_HIGH_LIMIT = 1'b1
    } t_reg_idx;

    // Acceptance window handed to the front end
    typedef struct packed {
        logic [CM_W-1:0] low;
        logic [CM_W-1:0] high;
    } t_limits;

    // Front end to queue write side
    typedef struct packed {
        logic            valid;
        logic [CM_W-1:0] dist_cm;
    } t_push;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// File: hw/rtl/edma_if.sv
interface edma_in_if;
    logic                      valid;
    logic                      ready;
    logic [edma_pkg::PW_W-1:0] pulse_width_us;

    modport source (output valid, output pulse_width_us, input ready);
    modport sink   (input valid, input pulse_width_us, output ready);
endinterface

interface edma_out_if;
    logic                      valid;
    logic                      ready;
    logic [edma_pkg::CM_W-1:0] sample_cm;
    logic [edma_pkg::CM_W-1:0] average_cm;

    modport source (output valid, output sample_cm, output average_cm, input ready);
    modport sink   (input valid, input sample_cm, input average_cm, output ready);
endinterface

// File: hw/rtl/edma_front.sv
module edma_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    edma_in_if.sink           i_in,
    input  edma_pkg::t_limits i_limits,
    input  logic              i_push_ready,
    output edma_pkg::t_push   o_push
);

    logic                                r_v;
    logic [edma_pkg::DIST_W-1:0]         r_dist;
    logic [edma_pkg::PW_W-2:0]           w_half;
    logic [edma_pkg::DIST_X_W-1:0]       w_x;
    logic [edma_pkg::DIST_P_W-1:0]       w_prod;
    logic [edma_pkg::DIST_W-1:0]         n_dist;
    logic                                w_keep;
    logic                                w_advance;

    // Width to centimetres: halve, times ten, reciprocal multiply by 1/291
    assign w_half = i_in.pulse_width_us[edma_pkg::PW_W-1:1];
    assign w_x    = edma_pkg::DIST_X_W'({w_half, 3'b000})
                  + edma_pkg::DIST_X_W'({w_half, 1'b0});
    assign w_prod = edma_pkg::DIST_P_W'(w_x) * edma_pkg::DIST_P_W'(edma_pkg::DIST_MULT);
    assign n_dist = w_prod[edma_pkg::DIST_SHIFT +: edma_pkg::DIST_W];

    // Classify the registered distance against the limits, full width
    assign w_keep = (r_dist > {1'b0, i_limits.low})
                 && (r_dist < {1'b0, i_limits.high});

    // Discarded items always drain; kept ones wait for queue space
    assign w_advance   = !r_v || !w_keep || i_push_ready;
    assign i_in.ready  = w_advance;

    assign o_push.valid   = r_v && w_keep;
    assign o_push.dist_cm = r_dist[edma_pkg::CM_W-1:0];

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_advance) begin
            r_v <= i_in.valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (w_advance && i_in.valid) begin
            r_dist <= n_dist;
        end
    end

endmodule

// File: hw/rtl/edma_fifo.sv
module edma_fifo #(
    parameter int DEPTH = edma_pkg::FIFO_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  edma_pkg::t_push           i_push,
    input  logic                      i_pop,
    output logic [edma_pkg::CM_W-1:0] o_data,
    output edma_pkg::t_fifo_stat      o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [edma_pkg::CM_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]          r_wp;
    logic [PTR_W-1:0]          r_rp;
    logic [CNT_W-1:0]          r_cnt;
    logic                      w_wr;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_wr         = i_push.valid && !o_stat.full;
    assign o_data       = r_mem[r_rp];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_push.dist_cm;
        end
    end

endmodule

// File: hw/rtl/edma_back.sv
module edma_back #(
    parameter int WINDOW = edma_pkg::WINDOW_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_avail,
    input  logic [edma_pkg::CM_W-1:0] i_dist,
    output logic                      o_pop,
    edma_out_if.source                o_out
);

    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int NUM_W     = edma_pkg::SUM_W + 1;
    localparam int DIV       = 2 * WINDOW;
    localparam int AVG_SHIFT = NUM_W + $clog2(DIV);
    localparam int AVG_MULT  = ((1 << AVG_SHIFT) + DIV - 1) / DIV;
    localparam int PROD_W    = NUM_W + AVG_SHIFT;

    logic [edma_pkg::CM_W-1:0]  r_win [WINDOW];
    logic [SLOT_W-1:0]          r_slot;
    logic [edma_pkg::SUM_W-1:0] r_sum;
    logic [edma_pkg::SUM_W-1:0] n_sum;

    logic                       r_m_v;
    logic [edma_pkg::CM_W-1:0]  r_m_sample;
    logic [edma_pkg::SUM_W-1:0] r_m_sum;

    logic                       r_o_v;
    logic [edma_pkg::CM_W-1:0]  r_o_sample;
    logic [edma_pkg::CM_W-1:0]  r_o_avg;

    logic                       w_load_o;
    logic [NUM_W-1:0]           w_num;
    logic [PROD_W-1:0]          w_prod;

    // Handshake chain: output register, then sum stage, then queue pop
    assign w_load_o = r_m_v && (!r_o_v || o_out.ready);
    assign o_pop    = i_avail && (!r_m_v || w_load_o);

    // Ring update: drop the oldest entry, add the new one
    assign n_sum = r_sum - r_win[r_slot] + edma_pkg::SUM_W'(i_dist);

    // Rounded mean: floor((2*sum + W) / 2W) by reciprocal multiply
    assign w_num  = {r_m_sum, 1'b0} + NUM_W'(WINDOW);
    assign w_prod = PROD_W'(w_num) * PROD_W'(AVG_MULT);

    // Window, sum and slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= '0;
            end
            r_sum  <= '0;
            r_slot <= '0;
        end else if (o_pop) begin
            r_win[r_slot] <= i_dist;
            r_sum         <= n_sum;
            r_slot        <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
        end
    end

    // Sum stage and output register valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (o_pop) begin
                r_m_v <= 1'b1;
            end else if (w_load_o) begin
                r_m_v <= 1'b0;
            end
            if (w_load_o) begin
                r_o_v <= 1'b1;
            end else if (o_out.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_sample <= i_dist;
            r_m_sum    <= n_sum;
        end
        if (w_load_o) begin
            r_o_sample <= r_m_sample;
            r_o_avg    <= w_prod[AVG_SHIFT +: edma_pkg::CM_W];
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.sample_cm  = r_o_sample;
    assign o_out.average_cm = r_o_avg;

endmodule

// File: hw/rtl/echo_distance_moving_average.sv
// A kept item passes the front-end stage register, the queue, the sum stage
// and the output register, in that order, before its result is valid.
// Throughput: one item per cycle while the output is not stalled; the window
// and sum update once per popped item, and a queue (four entries by default)
// separates classification from the update. Discarded items give no result.
// Reset (synchronous, active low): limits go to 2 and 400 cm, the window,
// sum and slot clear to zero, and all pipeline and queue valids drop.
module echo_distance_moving_average #(
    parameter int WINDOW     = edma_pkg::WINDOW_DEF,
    parameter int FIFO_DEPTH = edma_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    edma_in_if.sink                     i_in,
    edma_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [edma_pkg::APB_AW-1:0] paddr,
    input  logic [edma_pkg::APB_DW-1:0] pwdata,
    output logic [edma_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    logic [edma_pkg::CM_W-1:0] r_low;
    logic [edma_pkg::CM_W-1:0] r_high;
    edma_pkg::t_limits         w_limits;
    edma_pkg::t_reg_idx        w_idx;
    logic                      w_wr;

    edma_pkg::t_push           w_push;
    edma_pkg::t_fifo_stat      w_stat;
    logic [edma_pkg::CM_W-1:0] w_fifo_data;
    logic                      w_pop;

    // Register decode
    assign pready = 1'b1;
    assign w_idx  = edma_pkg::t_reg_idx'(paddr[edma_pkg::APB_AW-1]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= edma_pkg::LOW_RST;
            r_high <= edma_pkg::HIGH_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                edma_pkg::REG_LOW_LIMIT:  r_low  <= pwdata[edma_pkg::CM_W-1:0];
                edma_pkg::REG_HIGH_LIMIT: r_high <= pwdata[edma_pkg::CM_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            edma_pkg::REG_LOW_LIMIT:  prdata = edma_pkg::APB_DW'(r_low);
            edma_pkg::REG_HIGH_LIMIT: prdata = edma_pkg::APB_DW'(r_high);
            default:                  prdata = '0;
        endcase
    end

    assign w_limits.low  = r_low;
    assign w_limits.high = r_high;

    // Front end: convert and classify
    edma_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_limits     (w_limits),
        .i_push_ready (!w_stat.full),
        .o_push       (w_push)
    );

    // Queue between front and back
    edma_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_data  (w_fifo_data),
        .o_stat  (w_stat)
    );

    // Back end: window update and average
    edma_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!w_stat.empty),
        .i_dist  (w_fifo_data),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // Front never offers a kept distance into a full queue without holding
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid && w_stat.full |=> $past(w_push.valid) && !i_in.ready ||
            !$past(w_stat.full) || $stable(w_push.dist_cm))
        else $error("kept distance lost at full queue");

    // Back end pops only when the queue holds an entry
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("pop from empty queue");

    // A write into a queue that is not popped leaves it non-empty
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid && !w_stat.full && !w_pop |=> !w_stat.empty)
        else $error("queue empty after write");

endmodule

// File: verif/edma_checker.sv
`timescale 1ns / 1ps

module edma_checker #(
    parameter int WINDOW = edma_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    edma_in_if                          i_in_mon,
    edma_out_if                         i_out_mon,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [edma_pkg::APB_AW-1:0] paddr,
    input  logic [edma_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    output int                          o_err_count,
    output int                          o_pending
);

    // Half the echo time times 10/291 gives centimetres
    localparam int CM_NUM = 10;
    localparam int CM_DEN = 291;

    typedef struct packed {
        logic [edma_pkg::CM_W-1:0] sample;
        logic [edma_pkg::CM_W-1:0] average;
    } t_range_result;

    // Predicted block state
    logic [edma_pkg::CM_W-1:0]  low_cm;
    logic [edma_pkg::CM_W-1:0]  high_cm;
    logic [edma_pkg::CM_W-1:0]  win_ring [WINDOW];
    logic [edma_pkg::SUM_W-1:0] win_sum;
    int unsigned                win_slot;

    // Results still to come out, oldest first
    t_range_result range_q [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        o_err_count++;
    endtask

    function automatic logic [edma_pkg::DIST_W-1:0] pulse_to_cm(
        input logic [edma_pkg::PW_W-1:0] width
    );
        int unsigned half_w;
        half_w = width >> 1;
        return edma_pkg::DIST_W'((half_w * CM_NUM) / CM_DEN);
    endfunction

    // Classify one pulse; a kept distance goes into the ring and yields a result
    task automatic log_pulse(input logic [edma_pkg::PW_W-1:0] width);
        logic [edma_pkg::DIST_W-1:0] dist_cm;
        t_range_result               res;
        dist_cm = pulse_to_cm(width);
        if (dist_cm < {1'b0, high_cm} && dist_cm > {1'b0, low_cm}) begin
            win_sum = win_sum - win_ring[win_slot] + edma_pkg::SUM_W'(dist_cm);
            win_ring[win_slot] = dist_cm[edma_pkg::CM_W-1:0];
            win_slot = (win_slot == WINDOW - 1) ? 0 : win_slot + 1;
            res.sample  = dist_cm[edma_pkg::CM_W-1:0];
            res.average = edma_pkg::CM_W'((2 * int'(win_sum) + WINDOW) / (2 * WINDOW));
            range_q.push_back(res);
        end
    endtask

    task automatic check_result(input logic [edma_pkg::CM_W-1:0] sample,
                                input logic [edma_pkg::CM_W-1:0] average);
        t_range_result want;
        if (range_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result sample_cm=%0d average_cm=%0d",
                                      sample, average));
        end else begin
            want = range_q.pop_front();
            if (sample !== want.sample)
                report_mismatch($sformatf("sample_cm got %0d, expected %0d",
                                          sample, want.sample));
            if (average !== want.average)
                report_mismatch($sformatf("average_cm got %0d, expected %0d",
                                          average, want.average));
        end
    endtask

    // Watch register writes and both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            low_cm   = edma_pkg::LOW_RST;
            high_cm  = edma_pkg::HIGH_RST;
            win_sum  = '0;
            win_slot = 0;
            foreach (win_ring[k]) win_ring[k] = '0;
            range_q.delete();
            o_err_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (edma_pkg::t_reg_idx'(paddr[edma_pkg::APB_AW-1:2]))
                    edma_pkg::REG_LOW_LIMIT:  low_cm  = pwdata[edma_pkg::CM_W-1:0];
                    edma_pkg::REG_HIGH_LIMIT: high_cm = pwdata[edma_pkg::CM_W-1:0];
                    default: ;
                endcase
            end
            // check before predicting so a result never matches its own transfer
            if (i_out_mon.valid && i_out_mon.ready)
                check_result(i_out_mon.sample_cm, i_out_mon.average_cm);
            if (i_in_mon.valid && i_in_mon.ready)
                log_pulse(i_in_mon.pulse_width_us);
        end
        o_pending = range_q.size();
    end

endmodule

// File: verif/tb_echo_distance_moving_average.sv
`timescale 1ns / 1ps

module tb_echo_distance_moving_average;

    localparam int WINDOW         = edma_pkg::WINDOW_DEF;
    localparam int LONG_HOLD      = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CM_NUM         = 10;
    localparam int CM_DEN         = 291;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [edma_pkg::APB_AW-1:0] paddr;
    logic [edma_pkg::APB_DW-1:0] pwdata;
    logic [edma_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    edma_in_if  in_ch ();
    edma_out_if out_ch ();

    int err_count;
    int pending_cnt;

    // Stimulus to receiver process: long hold-off requests and the no-idle tail
    int hold_seq = 0;
    bit tail_no_idle = 1'b0;
    int rdy_gap;
    int hold_seen;
    int idle_cycles = 0;

    // Acceptance window currently programmed
    int unsigned lo_cm = edma_pkg::LOW_RST;
    int unsigned hi_cm = edma_pkg::HIGH_RST;

    echo_distance_moving_average #(
        .WINDOW (WINDOW)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    edma_checker #(
        .WINDOW (WINDOW)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_err_count (err_count),
        .o_pending   (pending_cnt)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rdy_gap = 0;
            hold_seen = hold_seq;
            out_ch.ready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            rdy_gap = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else if (rdy_gap != 0) begin
            rdy_gap--;
            out_ch.ready <= 1'b0;
        end else if (!tail_no_idle && $urandom_range(0, 7) == 0) begin
            rdy_gap = $urandom_range(0, 11);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Smallest pulse width that converts to d centimetres
    function automatic logic [edma_pkg::PW_W-1:0] width_for_cm(input int unsigned d);
        return edma_pkg::PW_W'(2 * ((d * CM_DEN + CM_NUM - 1) / CM_NUM));
    endfunction

    // Mostly widths that land inside the window, the rest any width
    function automatic logic [edma_pkg::PW_W-1:0] random_pulse();
        int unsigned d;
        if (lo_cm + 1 < hi_cm && $urandom_range(0, 3) != 0) begin
            d = $urandom_range(lo_cm + 1, hi_cm - 1);
            return edma_pkg::PW_W'($urandom_range(width_for_cm(d),
                                                  width_for_cm(d + 1) - 1));
        end
        return edma_pkg::PW_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic send_pulse(input logic [edma_pkg::PW_W-1:0] width);
        if (!tail_no_idle && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pulse_width_us <= width;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Wait for every expected result, then let discarded items clear the pipe
    task automatic drain_results();
        do @(negedge i_clk); while (pending_cnt != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input edma_pkg::t_reg_idx idx,
                             input logic [edma_pkg::CM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= edma_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input int unsigned lo, input int unsigned hi);
        write_reg(edma_pkg::REG_LOW_LIMIT, edma_pkg::CM_W'(lo));
        write_reg(edma_pkg::REG_HIGH_LIMIT, edma_pkg::CM_W'(hi));
        lo_cm = lo;
        hi_cm = hi;
    endtask

    task automatic send_list(input logic [edma_pkg::PW_W-1:0] widths [$]);
        foreach (widths[k]) send_pulse(widths[k]);
        in_ch.valid <= 1'b0;
        drain_results();
    endtask

    task automatic run_phase(input int n_items, input bit with_hold);
        if (with_hold) hold_seq <= hold_seq + 1;
        repeat (n_items) send_pulse(random_pulse());
        in_ch.valid <= 1'b0;
        drain_results();
    endtask

    initial begin
        int unsigned lo;
        int unsigned hi;

        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.pulse_width_us <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits: field extremes and both edges of the window
        send_list('{16'd0, 16'hFFFF, 16'hAAAA, 16'h5555, 16'd1,
                    width_for_cm(2), width_for_cm(3) - 1, width_for_cm(3),
                    width_for_cm(399), width_for_cm(400) - 1, width_for_cm(400)});

        // Widest limits: zero and out-of-field distances dropped, ring wraps at 1022
        set_limits(0, 1023);
        send_list('{width_for_cm(0), width_for_cm(1), width_for_cm(1023) - 1,
                    width_for_cm(1023), 16'hFFFF,
                    width_for_cm(1022), width_for_cm(1022) + 1, width_for_cm(1022),
                    width_for_cm(1022) + 1, width_for_cm(1022), width_for_cm(1022) + 1});

        // Random phases over several windows, fill-up stall in the first
        set_limits(edma_pkg::LOW_RST, edma_pkg::HIGH_RST);
        run_phase(150, 1'b1);
        set_limits(0, 1023);
        run_phase(120, 1'b0);
        // crossed limits: nothing passes
        set_limits(1023, 0);
        run_phase(30, 1'b0);
        set_limits(5, 6);
        run_phase(30, 1'b0);
        // single passing distance
        set_limits(50, 52);
        run_phase(40, 1'b0);
        repeat (3) begin
            lo = $urandom_range(0, 600);
            hi = $urandom_range(lo + 2, 1023);
            set_limits(lo, hi);
            run_phase(100, 1'b0);
        end

        // Tail at full rate
        set_limits(edma_pkg::LOW_RST, edma_pkg::HIGH_RST);
        tail_no_idle <= 1'b1;
        run_phase(150, 1'b0);

        if (err_count == 0 && pending_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
